// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

   // Storage geometry
   localparam int DEPTH_DEFAULT = 8;
   localparam int DATA_WIDTH    = 32;
   localparam int COUNT_OUT_W   = 4;

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef logic [COUNT_OUT_W-1:0]       count_out_type;

   // Request operation codes
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } op_type;

   // Response status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // Word returned on underflow
   localparam word_type EMPTY_WORD = '1;

endpackage

// ===== rtl/deq_ram.sv =====
`timescale 1ns / 1ps

module deq_ram #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  deq_pkg::word_type          wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output deq_pkg::word_type          rd_data
);
   import deq_pkg::*;

   word_type mem [DEPTH];
   word_type rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Bounded double-ended queue held in a circular buffer of DEPTH words.
// The response strobe rises in the cycle after the request is taken.
// One request per clock; the slot RAM read of a pop or peek
// lands in its output register along with the strobe, and head/count update at accept.
// Reset (synchronous, active high) empties the queue; the slot RAM is not cleared.
// The receiver cannot stall: each response is valid for exactly one cycle.
module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [2:0]              req_operation,
   input  deq_pkg::word_type       req_push_value,
   output logic                    rsp_valid,
   output deq_pkg::word_type       rsp_data_out,
   output logic [1:0]              rsp_status,
   output deq_pkg::count_out_type  rsp_fill_count_out,
   output logic                    rsp_is_empty_flag,
   output logic                    rsp_is_full_flag
);
   import deq_pkg::*;

   localparam int IdxW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam int SumW = IdxW + 1;

   logic [IdxW-1:0] head_ff, head_in;
   logic [CntW-1:0] count_ff, count_in;

   logic            rsp_valid_ff;
   word_type        rsp_data_ff, rsp_data_in;
   status_type      rsp_status_ff, rsp_status_in;
   logic            rsp_from_mem_ff, rsp_from_mem_in;

   logic            accept;
   logic            q_empty, q_full;
   logic [IdxW-1:0] head_prev, head_next, back_slot, tail_slot;
   logic [SumW-1:0] back_sum, tail_sum;
   logic            wr_en, rd_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   word_type        rd_data;
   logic [CntW+COUNT_OUT_W-1:0] count_wide;

   // Never stalls: every request completes its state update at accept
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign q_empty = (count_ff == '0);
   assign q_full  = (count_ff == CntW'(DEPTH));

   // Circular index arithmetic
   assign head_prev = (head_ff == '0) ? IdxW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_next = (head_ff == IdxW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign back_sum  = SumW'(head_ff) + SumW'(count_ff);
   assign tail_sum  = SumW'(head_ff) + SumW'(count_ff) - 1'b1;
   assign back_slot = (back_sum >= SumW'(DEPTH)) ? IdxW'(back_sum - SumW'(DEPTH))
                                                 : IdxW'(back_sum);
   assign tail_slot = (tail_sum >= SumW'(DEPTH)) ? IdxW'(tail_sum - SumW'(DEPTH))
                                                 : IdxW'(tail_sum);

   // Request decode: pointer updates, RAM access, response fields
   always_comb begin
      head_in         = head_ff;
      count_in        = count_ff;
      wr_en           = 1'b0;
      wr_addr         = back_slot;
      rd_en           = 1'b0;
      rd_addr         = head_ff;
      rsp_data_in     = '0;
      rsp_status_in   = ST_OK;
      rsp_from_mem_in = 1'b0;
      if (accept) begin
         case (req_operation)
            OP_PUSH_FRONT: begin
               if (q_full) begin
                  rsp_status_in = ST_OVERFLOW;
               end else begin
                  head_in  = head_prev;
                  count_in = count_ff + 1'b1;
                  wr_en    = 1'b1;
                  wr_addr  = head_prev;
               end
            end
            OP_PUSH_BACK: begin
               if (q_full) begin
                  rsp_status_in = ST_OVERFLOW;
               end else begin
                  count_in = count_ff + 1'b1;
                  wr_en    = 1'b1;
                  wr_addr  = back_slot;
               end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
               if (q_empty) begin
                  rsp_status_in = ST_UNDERFLOW;
                  rsp_data_in   = EMPTY_WORD;
               end else begin
                  rd_en           = 1'b1;
                  rd_addr         = head_ff;
                  rsp_from_mem_in = 1'b1;
                  if (req_operation == OP_POP_FRONT) begin
                     head_in  = head_next;
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
               if (q_empty) begin
                  rsp_status_in = ST_UNDERFLOW;
                  rsp_data_in   = EMPTY_WORD;
               end else begin
                  rd_en           = 1'b1;
                  rd_addr         = tail_slot;
                  rsp_from_mem_in = 1'b1;
                  if (req_operation == OP_POP_BACK) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            default: begin
               // unused codes: no change, report current state
            end
         endcase
      end
   end

   // Pointer and strobe registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_data_ff     <= rsp_data_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_from_mem_ff <= rsp_from_mem_in;
   end

   deq_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Count and flags follow the updated state, visible with the strobe
   assign count_wide = {{COUNT_OUT_W{1'b0}}, count_ff};

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_out       = rsp_from_mem_ff ? rd_data : rsp_data_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_fill_count_out = count_wide[COUNT_OUT_W-1:0];
   assign rsp_is_empty_flag  = q_empty;
   assign rsp_is_full_flag   = q_full;

endmodule
